// ===== rtl/rc4_pkg.sv =====
// Shared types and constants for the RC4 stream cipher engine.
// Holds the microcode word layout, step addresses and the program ROM.
// No dependencies.
`timescale 1ns / 1ps

package rc4_pkg;

   localparam int PERM_W        = 8;
   localparam int PERM_SIZE     = 256;
   localparam int DROP_W        = 12;
   localparam int DROP_PASSES   = 3;
   localparam int DROP_PASS_LEN = 1024;
   localparam logic [DROP_W-1:0] DROP_RESET = DROP_W'(DROP_PASSES * DROP_PASS_LEN);

   localparam logic OPC_KEY  = 1'b0;
   localparam logic OPC_DATA = 1'b1;

   localparam int PC_W = 4;
   typedef logic [PC_W-1:0] pc_type;

   localparam pc_type PC_IDLE = 4'd0;
   localparam pc_type PC_INIT = 4'd1;
   localparam pc_type PC_K0   = 4'd2;
   localparam pc_type PC_K1   = 4'd3;
   localparam pc_type PC_K2   = 4'd4;
   localparam pc_type PC_K3   = 4'd5;
   localparam pc_type PC_KEND = 4'd6;
   localparam pc_type PC_P0   = 4'd7;
   localparam pc_type PC_P1   = 4'd8;
   localparam pc_type PC_P2   = 4'd9;
   localparam pc_type PC_P3   = 4'd10;
   localparam pc_type PC_EMIT = 4'd11;
   localparam pc_type PC_FIN  = 4'd12;

   typedef enum logic [2:0] {
      COND_NEXT,
      COND_JUMP,
      COND_LOOP,
      COND_DISPATCH,
      COND_SKIP_DROP,
      COND_STREAM,
      COND_WAIT_RSP
   } cond_type;

   typedef enum logic [1:0] {
      RA_I,
      RA_I_NEXT,
      RA_J_SUM,
      RA_T
   } raddr_sel_type;

   typedef enum logic [1:0] {
      WR_NONE,
      WR_INIT,
      WR_I_RD,
      WR_J_SI
   } wr_sel_type;

   typedef struct packed {
      logic          ready;
      raddr_sel_type raddr_sel;
      wr_sel_type    wr_sel;
      logic          j_sum;
      logic          i_inc;
      logic          key_mix;
      logic          si_load;
      logic          sj_load;
      logic          ks_load;
      logic          emit;
      logic          set_keyed;
      logic          kend;
      cond_type      cond;
      pc_type        target;
   } ctrl_word_type;

   localparam ctrl_word_type CW_NOP = '{
      ready: 1'b0, raddr_sel: RA_I, wr_sel: WR_NONE, j_sum: 1'b0, i_inc: 1'b0,
      key_mix: 1'b0, si_load: 1'b0, sj_load: 1'b0, ks_load: 1'b0, emit: 1'b0,
      set_keyed: 1'b0, kend: 1'b0, cond: COND_JUMP, target: PC_IDLE
   };

   function automatic ctrl_word_type ucode_rom(input pc_type pc);
      ctrl_word_type cw;
      cw = CW_NOP;
      unique case (pc)
         PC_IDLE: begin
            cw.ready  = 1'b1;
            cw.cond   = COND_DISPATCH;
            cw.target = PC_INIT;
         end
         PC_INIT: begin
            cw.wr_sel = WR_INIT;
            cw.i_inc  = 1'b1;
            cw.cond   = COND_LOOP;
            cw.target = PC_INIT;
         end
         PC_K0: begin
            cw.raddr_sel = RA_I;
            cw.cond      = COND_NEXT;
         end
         PC_K1: begin
            cw.si_load   = 1'b1;
            cw.key_mix   = 1'b1;
            cw.j_sum     = 1'b1;
            cw.raddr_sel = RA_J_SUM;
            cw.cond      = COND_NEXT;
         end
         PC_K2: begin
            cw.wr_sel = WR_I_RD;
            cw.cond   = COND_NEXT;
         end
         PC_K3: begin
            cw.wr_sel = WR_J_SI;
            cw.i_inc  = 1'b1;
            cw.cond   = COND_LOOP;
            cw.target = PC_K0;
         end
         PC_KEND: begin
            cw.kend   = 1'b1;
            cw.cond   = COND_SKIP_DROP;
            cw.target = PC_FIN;
         end
         PC_P0: begin
            cw.i_inc     = 1'b1;
            cw.raddr_sel = RA_I_NEXT;
            cw.cond      = COND_NEXT;
         end
         PC_P1: begin
            cw.si_load   = 1'b1;
            cw.j_sum     = 1'b1;
            cw.raddr_sel = RA_J_SUM;
            cw.cond      = COND_NEXT;
         end
         PC_P2: begin
            cw.wr_sel    = WR_I_RD;
            cw.sj_load   = 1'b1;
            cw.raddr_sel = RA_T;
            cw.cond      = COND_NEXT;
         end
         PC_P3: begin
            cw.wr_sel  = WR_J_SI;
            cw.ks_load = 1'b1;
            cw.cond    = COND_STREAM;
            cw.target  = PC_FIN;
         end
         PC_EMIT: begin
            cw.emit   = 1'b1;
            cw.cond   = COND_WAIT_RSP;
            cw.target = PC_IDLE;
         end
         PC_FIN: begin
            cw.set_keyed = 1'b1;
            cw.cond      = COND_JUMP;
            cw.target    = PC_IDLE;
         end
         default: cw = CW_NOP;
      endcase
      return cw;
   endfunction

endpackage

// ===== rtl/rc4_stream_cipher.sv =====
// RC4 stream cipher engine with keystream drop, top level.
// Depends on rc4_pkg (microcode ROM, types) and rc4_ram (permutation, key store).
//
// Usage: requests on req_* carry an opcode, a byte and a last flag. Key
// requests (opcode 0) fill the key store; the one with last set runs the
// key schedule and then discards csr_wdata-programmed drop bytes (3072
// after reset). Data requests (opcode 1) return one response on rsp_*:
// the byte XOR the next keystream byte, or the byte unchanged with
// rsp_unkeyed set if no key has been scheduled yet.
// A key byte is taken at dispatch. An unkeyed data byte adds the response
// load step, a keyed one four keystream steps and the response load. A key
// schedule fills 256 entries, then runs four mix steps per entry and four
// keystream steps per dropped byte, all bound by the single read port of
// the permutation RAM. req_ready is low while an item is in progress.
// Responses sit in an output register; the next request is accepted while
// one waits, and a new response stalls in its load step until rsp_ready.
// Reset (synchronous) clears the indices, key count and keyed state and
// restores the drop count; RAM contents are left as they are.
`timescale 1ns / 1ps

module rc4_stream_cipher
   import rc4_pkg::*;
#(
   parameter int KEY_DEPTH = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_opcode,
   input  logic [7:0]        req_data_byte,
   input  logic              req_last_of_run,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_unkeyed,
   output logic              rsp_end_of_buffer,
   input  logic              csr_we,
   input  logic [DROP_W-1:0] csr_wdata
);

   localparam int KW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
   localparam int CW = $clog2(KEY_DEPTH + 1);
   localparam logic [CW-1:0] KEY_FULL = CW'(KEY_DEPTH);
   localparam logic [PERM_W-1:0] IDX_LAST = PERM_W'(PERM_SIZE - 1);

   ctrl_word_type cw;

   pc_type pc_ff, pc_in;
   logic [PERM_W-1:0] i_ff, i_in, j_ff, j_in;
   logic [PERM_W-1:0] si_ff, sj_ff, t_ff, ks_ff;
   logic [CW-1:0]     key_count_ff, key_count_in, k_ff, k_in;
   logic [DROP_W-1:0] drop_bytes_ff, drop_cnt_ff, drop_cnt_in;
   logic              keyed_ff, data_mode_ff, data_mode_in;
   logic [7:0]        byte_ff;
   logic              last_ff;
   logic              rsp_valid_ff;
   logic [7:0]        rsp_byte_ff;
   logic              rsp_unkeyed_ff, rsp_eob_ff;

   logic              req_fire, rsp_busy, emit_fire;
   logic              perm_we, key_we;
   logic [PERM_W-1:0] perm_waddr, perm_wdata, perm_raddr, perm_rd, j_sum, ks_val;
   logic [PERM_W-1:0] key_rd, kb;
   logic [CW:0]       k_plus;

   assign cw        = ucode_rom(pc_ff);
   assign req_ready = cw.ready;
   assign req_fire  = req_valid & cw.ready;
   assign rsp_busy  = rsp_valid_ff & ~rsp_ready;
   assign emit_fire = cw.emit & ~rsp_busy;

   // key store: written at the fill count, read continuously at k
   assign key_we = req_fire & (req_opcode == OPC_KEY) & (key_count_ff < KEY_FULL);

   rc4_ram #(.WIDTH(8), .DEPTH(KEY_DEPTH)) u_key_ram (
      .clock (clock),
      .we    (key_we),
      .waddr (key_count_ff[KW-1:0]),
      .wdata (req_data_byte),
      .raddr (k_ff[KW-1:0]),
      .rdata (key_rd)
   );

   rc4_ram #(.WIDTH(PERM_W), .DEPTH(PERM_SIZE)) u_perm_ram (
      .clock (clock),
      .we    (perm_we),
      .waddr (perm_waddr),
      .wdata (perm_wdata),
      .raddr (perm_raddr),
      .rdata (perm_rd)
   );

   assign kb     = (cw.key_mix && key_count_ff != '0) ? key_rd : '0;
   assign j_sum  = j_ff + perm_rd + kb;
   assign k_plus = {1'b0, k_ff} + {{CW{1'b0}}, 1'b1};

   // S[t] read raced the swap writes; forward the swapped values
   assign ks_val = (t_ff == i_ff) ? sj_ff : ((t_ff == j_ff) ? si_ff : perm_rd);

   always_comb begin
      unique case (cw.raddr_sel)
         RA_I:      perm_raddr = i_ff;
         RA_I_NEXT: perm_raddr = i_ff + 1'b1;
         RA_J_SUM:  perm_raddr = j_sum;
         RA_T:      perm_raddr = si_ff + perm_rd;
         default:   perm_raddr = i_ff;
      endcase
   end

   always_comb begin
      perm_we    = 1'b1;
      perm_waddr = i_ff;
      perm_wdata = perm_rd;
      unique case (cw.wr_sel)
         WR_NONE: perm_we = 1'b0;
         WR_INIT: perm_wdata = i_ff;
         WR_I_RD: perm_wdata = perm_rd;
         WR_J_SI: begin
            perm_waddr = j_ff;
            perm_wdata = si_ff;
         end
         default: perm_we = 1'b0;
      endcase
   end

   // sequencer next address
   always_comb begin
      unique case (cw.cond)
         COND_NEXT: pc_in = pc_ff + 1'b1;
         COND_JUMP: pc_in = cw.target;
         COND_LOOP: pc_in = (i_ff == IDX_LAST) ? pc_ff + 1'b1 : cw.target;
         COND_DISPATCH: begin
            if (!req_fire) begin
               pc_in = pc_ff;
            end else if (req_opcode == OPC_DATA) begin
               pc_in = keyed_ff ? PC_P0 : PC_EMIT;
            end else begin
               pc_in = req_last_of_run ? cw.target : pc_ff;
            end
         end
         COND_SKIP_DROP: pc_in = (drop_bytes_ff == '0) ? cw.target : pc_ff + 1'b1;
         COND_STREAM: begin
            if (data_mode_ff) begin
               pc_in = pc_ff + 1'b1;
            end else begin
               pc_in = (drop_cnt_ff == DROP_W'(1)) ? cw.target : PC_P0;
            end
         end
         COND_WAIT_RSP: pc_in = rsp_busy ? pc_ff : cw.target;
         default: pc_in = PC_IDLE;
      endcase
   end

   // datapath next values
   always_comb begin
      i_in         = cw.i_inc ? i_ff + 1'b1 : i_ff;
      j_in         = cw.j_sum ? j_sum : j_ff;
      k_in         = k_ff;
      key_count_in = key_count_ff;
      drop_cnt_in  = drop_cnt_ff;
      data_mode_in = data_mode_ff;
      if (cw.key_mix) begin
         k_in = (k_plus >= {1'b0, key_count_ff}) ? '0 : k_plus[CW-1:0];
      end
      if (req_fire) begin
         data_mode_in = (req_opcode == OPC_DATA);
         if (key_we) begin
            key_count_in = key_count_ff + 1'b1;
         end
         if (req_opcode == OPC_KEY && req_last_of_run) begin
            i_in = '0;
            j_in = '0;
            k_in = '0;
         end
      end
      if (cw.kend) begin
         j_in         = '0;
         key_count_in = '0;
         drop_cnt_in  = drop_bytes_ff;
      end
      if (cw.ks_load && !data_mode_ff) begin
         drop_cnt_in = drop_cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff         <= PC_IDLE;
         i_ff          <= '0;
         j_ff          <= '0;
         k_ff          <= '0;
         key_count_ff  <= '0;
         drop_bytes_ff <= DROP_RESET;
         drop_cnt_ff   <= '0;
         keyed_ff      <= 1'b0;
         data_mode_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         k_ff         <= k_in;
         key_count_ff <= key_count_in;
         drop_cnt_ff  <= drop_cnt_in;
         data_mode_ff <= data_mode_in;
         if (csr_we) begin
            drop_bytes_ff <= csr_wdata;
         end
         if (cw.set_keyed) begin
            keyed_ff <= 1'b1;
         end
         if (emit_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         byte_ff <= req_data_byte;
         last_ff <= req_last_of_run;
      end
      if (cw.si_load) begin
         si_ff <= perm_rd;
      end
      if (cw.sj_load) begin
         sj_ff <= perm_rd;
         t_ff  <= si_ff + perm_rd;
      end
      if (cw.ks_load) begin
         ks_ff <= ks_val;
      end
      if (emit_fire) begin
         rsp_byte_ff    <= keyed_ff ? (byte_ff ^ ks_ff) : byte_ff;
         rsp_unkeyed_ff <= ~keyed_ff;
         rsp_eob_ff     <= last_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_byte      = rsp_byte_ff;
   assign rsp_unkeyed       = rsp_unkeyed_ff;
   assign rsp_end_of_buffer = rsp_eob_ff;

   a_keyed_sticky: assert property (@(posedge clock) disable iff (reset)
      keyed_ff |=> keyed_ff)
      else $error("keyed state dropped");

   a_key_count_range: assert property (@(posedge clock) disable iff (reset)
      key_count_ff <= KEY_FULL)
      else $error("key count past store depth");

   a_key_index_range: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == PC_K3 && key_count_ff != '0) |-> k_ff < key_count_ff)
      else $error("key index beyond key length");

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(pc_ff) == PC_EMIT)
      else $error("response raised outside load step");

endmodule

// ===== rtl/rc4_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Read returns the old contents on a same-address write. No dependencies.
`timescale 1ns / 1ps

module rc4_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                                    clock,
   input  logic                                    we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                        wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                        rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for rc4_stream_cipher: a request driver and a response monitor,
// with an RC4 drop-N predictor that tracks the key store, permutation and drop setting.
// Depends on rc4_pkg and the rc4_stream_cipher RTL only.
`timescale 1ns / 1ps

module tb;
   import rc4_pkg::*;

   localparam int KEY_SLOTS = 256;
   localparam int PHASE_REQS = 190;
   localparam int MAX_SHOWN = 10;

   typedef struct packed {
      logic       op;
      logic [7:0] value;
      logic       is_last;
   } byte_req_t;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       unkeyed;
      logic       eob;
   } cipher_rsp_t;

   typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic              req_opcode;
   logic [7:0]        req_data_byte;
   logic              req_last_of_run;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [7:0]        rsp_out_byte;
   logic              rsp_unkeyed;
   logic              rsp_end_of_buffer;
   logic              csr_we;
   logic [DROP_W-1:0] csr_wdata;

   // predictor state
   logic [7:0]        sbox [PERM_SIZE];
   logic [7:0]        key_mem [KEY_SLOTS];
   logic [7:0]        ks_i;
   logic [7:0]        ks_j;
   int unsigned       key_len;
   bit                have_key;
   logic [DROP_W-1:0] drop_cnt;

   byte_req_t   byte_req_q[$];
   cipher_rsp_t cipher_out_q[$];
   byte_req_t   offered;
   int          reqs_queued = 0;
   int          reqs_accepted = 0;
   int          mismatches = 0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   bit          hold_armed = 1'b0;
   int          hold_left;

   rc4_stream_cipher u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_data_byte    (req_data_byte),
      .req_last_of_run  (req_last_of_run),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_unkeyed      (rsp_unkeyed),
      .rsp_end_of_buffer(rsp_end_of_buffer),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata)
   );

   always #1 clock = ~clock;

   function automatic logic [7:0] rc4_next_keystream();
      logic [7:0] t;
      ks_i = ks_i + 8'd1;
      ks_j = ks_j + sbox[ks_i];
      t = sbox[ks_i];
      sbox[ks_i] = sbox[ks_j];
      sbox[ks_j] = t;
      return sbox[8'(sbox[ks_i] + sbox[ks_j])];
   endfunction

   function automatic void rc4_schedule_key();
      logic [7:0] j;
      logic [7:0] t;
      logic [7:0] kb;
      int unsigned k;
      j = 8'd0;
      k = 0;
      for (int n = 0; n < PERM_SIZE; n++) sbox[n] = 8'(n);
      for (int n = 0; n < PERM_SIZE; n++) begin
         kb = (key_len != 0) ? key_mem[k] : 8'd0;
         j = j + kb + sbox[n];
         t = sbox[n];
         sbox[n] = sbox[j];
         sbox[j] = t;
         k++;
         if (k >= key_len) k = 0;
      end
      ks_i = 8'd0;
      ks_j = 8'd0;
      key_len = 0;
      for (int n = 0; n < drop_cnt; n++) void'(rc4_next_keystream());
      have_key = 1'b1;
   endfunction

   function automatic void rc4_predict_request(input byte_req_t rq);
      cipher_rsp_t rs;
      if (rq.op == OPC_KEY) begin
         // bytes past the key store are dropped, count saturates
         if (key_len < KEY_SLOTS) begin
            key_mem[key_len] = rq.value;
            key_len++;
         end
         if (rq.is_last) rc4_schedule_key();
      end else begin
         if (have_key) begin
            rs.out_byte = rq.value ^ rc4_next_keystream();
            rs.unkeyed  = 1'b0;
         end else begin
            rs.out_byte = rq.value;
            rs.unkeyed  = 1'b1;
         end
         rs.eob = rq.is_last;
         cipher_out_q.push_back(rs);
      end
   endfunction

   task automatic queue_req(input logic op, input logic [7:0] value, input logic is_last);
      byte_req_t rq;
      rq.op = op;
      rq.value = value;
      rq.is_last = is_last;
      byte_req_q.push_back(rq);
      reqs_queued++;
   endtask

   // One key followed by a data buffer; sometimes data lands mid-key or stray key bytes trail.
   task automatic queue_session(input int data_max);
      int r;
      int klen;
      int dlen;
      int split;
      r = $urandom_range(99);
      if (r < 4) klen = $urandom_range(300, 256);
      else if (r < 20) klen = 1;
      else klen = $urandom_range(16, 2);
      split = ($urandom_range(99) < 12) ? $urandom_range(klen - 1, 0) : -1;
      for (int n = 0; n < klen; n++) begin
         if (n == split) begin
            repeat ($urandom_range(4, 1))
               queue_req(OPC_DATA, 8'($urandom), 1'($urandom));
         end
         queue_req(OPC_KEY, 8'($urandom), n == klen - 1);
      end
      dlen = $urandom_range(data_max, 1);
      for (int n = 0; n < dlen; n++)
         queue_req(OPC_DATA, 8'($urandom), (n == dlen - 1) || ($urandom_range(99) < 10));
      if ($urandom_range(99) < 8) begin
         repeat ($urandom_range(3, 1)) queue_req(OPC_KEY, 8'($urandom), 1'b0);
      end
   endtask

   task automatic set_idle_mode(input idle_mode_t mode);
      send_idle_pct  = (mode == IDLE_SENDER) ? 79 : (mode == IDLE_BOTH) ? 8 : 0;
      recv_stall_pct = (mode == IDLE_RECEIVER) ? 79 : (mode == IDLE_BOTH) ? 8 : 0;
   endtask

   // Wait for all requests and responses, then let a possible key schedule finish.
   task automatic drain_and_settle();
      while (reqs_accepted != reqs_queued || cipher_out_q.size() != 0) @(posedge clock);
      repeat (1282 + 4 * int'(drop_cnt) + 64) @(posedge clock);
   endtask

   task automatic write_drop(input logic [DROP_W-1:0] v);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      drop_cnt = v;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // request driver
   always @(posedge clock) begin : drive_proc
      logic offering;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         offering = req_valid;
         if (req_valid && req_ready) begin
            rc4_predict_request(offered);
            reqs_accepted++;
            offering = 1'b0;
         end
         if (!offering && byte_req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            offered = byte_req_q.pop_front();
            req_opcode      <= offered.op;
            req_data_byte   <= offered.value;
            req_last_of_run <= offered.is_last;
            offering = 1'b1;
         end
         req_valid <= offering;
      end
   end

   // long receiver hold-off so the engine backs up and stalls requests
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_armed && rsp_valid && byte_req_q.size() > 20) begin
         hold_left <= 300;
         hold_armed = 1'b0;
      end
   end

   // response monitor
   always @(posedge clock) begin : watch_proc
      cipher_rsp_t want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (cipher_out_q.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_SHOWN)
                  $display("unexpected response: byte %02h unkeyed %0b eob %0b",
                           rsp_out_byte, rsp_unkeyed, rsp_end_of_buffer);
            end else begin
               want = cipher_out_q.pop_front();
               if (rsp_out_byte !== want.out_byte || rsp_unkeyed !== want.unkeyed ||
                   rsp_end_of_buffer !== want.eob) begin
                  mismatches++;
                  if (mismatches <= MAX_SHOWN)
                     $display({"mismatch at %0t: byte exp %02h got %02h, ",
                               "unkeyed exp %0b got %0b, eob exp %0b got %0b"},
                              $realtime, want.out_byte, rsp_out_byte, want.unkeyed,
                              rsp_unkeyed, want.eob, rsp_end_of_buffer);
               end
            end
         end
         rsp_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   initial begin : stimulus_proc
      logic [DROP_W-1:0] drop_val;
      int data_max;
      int phase_start;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_opcode      = OPC_KEY;
      req_data_byte   = 8'd0;
      req_last_of_run = 1'b0;
      rsp_ready       = 1'b0;
      csr_we          = 1'b0;
      csr_wdata       = '0;
      for (int n = 0; n < PERM_SIZE; n++) sbox[n] = 8'd0;
      for (int n = 0; n < KEY_SLOTS; n++) key_mem[n] = 8'd0;
      ks_i = 8'd0;
      ks_j = 8'd0;
      key_len = 0;
      have_key = 1'b0;
      drop_cnt = DROP_RESET;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed part, default drop count
      set_idle_mode(IDLE_NONE);
      @(negedge clock);
      // pass-through before any key
      queue_req(OPC_DATA, 8'h00, 1'b0);
      queue_req(OPC_DATA, 8'hFF, 1'b1);
      queue_req(OPC_DATA, 8'hA5, 1'b0);
      queue_req(OPC_DATA, 8'h5A, 1'b1);
      queue_req(OPC_KEY, 8'h4B, 1'b0);
      queue_req(OPC_KEY, 8'h65, 1'b0);
      queue_req(OPC_KEY, 8'h79, 1'b1);
      queue_req(OPC_DATA, 8'h00, 1'b0);
      queue_req(OPC_DATA, 8'hFF, 1'b0);
      queue_req(OPC_DATA, 8'h80, 1'b0);
      queue_req(OPC_DATA, 8'h01, 1'b1);
      // new key being collected; data still uses the old keystream
      queue_req(OPC_KEY, 8'hFF, 1'b0);
      queue_req(OPC_KEY, 8'h00, 1'b0);
      queue_req(OPC_DATA, 8'h3C, 1'b0);
      queue_req(OPC_DATA, 8'hC3, 1'b1);
      queue_req(OPC_KEY, 8'h7E, 1'b1);
      queue_req(OPC_DATA, 8'h55, 1'b1);
      // single-byte key of zero
      queue_req(OPC_KEY, 8'h00, 1'b1);
      queue_req(OPC_DATA, 8'hFF, 1'b0);
      queue_req(OPC_DATA, 8'h00, 1'b1);
      drain_and_settle();

      for (int p = 0; p < 6; p++) begin
         case (p)
            0: drop_val = '0;
            1: drop_val = '1;
            2: drop_val = 12'd1;
            3: drop_val = 12'($urandom_range(300, 2));
            4: drop_val = 12'($urandom_range(255, 0));
            default: drop_val = 12'($urandom_range(4095, 0));
         endcase
         write_drop(drop_val);
         set_idle_mode(idle_mode_t'(p % 4));
         // big drop counts make each key slow, so fewer keys and longer buffers
         data_max = (drop_val >= 12'd1024) ? 120 : 40;
         hold_armed = (p == 0);
         @(negedge clock);
         phase_start = reqs_queued;
         while (reqs_queued - phase_start < PHASE_REQS) queue_session(data_max);
         drain_and_settle();
      end

      if (cipher_out_q.size() != 0) begin
         mismatches++;
         $display("%0d responses never arrived", cipher_out_q.size());
      end
      if (mismatches == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/rc4_pkg.sv
rtl/rc4_ram.sv
rtl/rc4_stream_cipher.sv
tb/tb.sv
